// ----- src/rcbms_pkg.sv -----
package rcbms_pkg;

   localparam int WORD_BITS  = 32;
   localparam int WORD_SHIFT = 5;
   localparam int IDX_W      = 16;

   localparam logic [2:0] CMD_GET        = 3'd0;
   localparam logic [2:0] CMD_PUT        = 3'd1;
   localparam logic [2:0] CMD_SET        = 3'd2;
   localparam logic [2:0] CMD_CLEAR      = 3'd3;
   localparam logic [2:0] CMD_INVERT_ALL = 3'd4;
   localparam logic [2:0] CMD_CLEAR_ALL  = 3'd5;

   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_COL_COUNT = 1'b1;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] row;
      logic [15:0] col;
      logic        bit_in;
   } req_type;

   typedef struct packed {
      logic bit_out;
      logic ok;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_GET,
      OP_WRITE,
      OP_INVERT,
      OP_WIPE,
      OP_REJECT
   } op_kind_type;

   typedef struct packed {
      op_kind_type           kind;
      logic                  bit_val;
      logic [IDX_W-1:0]      word;
      logic [WORD_SHIFT-1:0] pos;
      logic [IDX_W-1:0]      count;
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MODIFY,
      ST_SWEEP
   } back_state_type;

endpackage

// ----- src/rcbms_ram.sv -----
module rcbms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/rcbms_front.sv -----
module rcbms_front
   import rcbms_pkg::*;
#(
   parameter int MAX_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   input  logic [15:0] row_count,
   input  logic [15:0] col_count,
   input  logic        clearing,
   input  logic        q_full,
   output logic        q_push,
   output op_type      q_op
);

   localparam logic [27:0] MAX_W28 = 28'(MAX_WORDS);

   logic        s_vld_ff, s_vld_in;
   logic [2:0]  s_cmd_ff;
   logic        s_range_ok_ff;
   logic [31:0] s_prod_ff;
   logic [15:0] s_col_ff;
   logic        s_bit_ff;

   logic        take;
   logic        whole;
   logic [15:0] mul_a;
   logic [32:0] offset;
   logic [32:0] used_sum;
   logic [27:0] word_idx;
   logic [27:0] used_raw;
   logic [IDX_W-1:0] used;
   logic        addr_ok;

   assign req_stall = clearing || (s_vld_ff && q_full);
   assign take      = req_valid && !req_stall;
   assign q_push    = s_vld_ff && !q_full;

   assign whole = (req_data.command == CMD_INVERT_ALL) || (req_data.command == CMD_CLEAR_ALL);
   assign mul_a = whole ? row_count : req_data.row;

   always_comb begin
      s_vld_in = s_vld_ff;
      if (take) begin
         s_vld_in = 1'b1;
      end else if (q_push) begin
         s_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= 1'b0;
      end else begin
         s_vld_ff <= s_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s_cmd_ff      <= req_data.command;
         s_range_ok_ff <= (req_data.row < row_count) && (req_data.col < col_count);
         s_prod_ff     <= 32'(mul_a) * 32'(col_count);
         s_col_ff      <= req_data.col;
         s_bit_ff      <= req_data.bit_in;
      end
   end

   // bit offset and used word count share the registered product
   assign offset   = 33'(s_prod_ff) + 33'(s_col_ff);
   assign word_idx = offset[32:WORD_SHIFT];
   assign used_sum = 33'(s_prod_ff) + 33'(WORD_BITS - 1);
   assign used_raw = used_sum[32:WORD_SHIFT];
   assign used     = (used_raw < MAX_W28) ? used_raw[IDX_W-1:0] : IDX_W'(MAX_WORDS);
   assign addr_ok  = s_range_ok_ff && (word_idx < MAX_W28);

   always_comb begin
      q_op.kind    = OP_REJECT;
      q_op.bit_val = 1'b0;
      q_op.word    = word_idx[IDX_W-1:0];
      q_op.pos     = WORD_SHIFT'(WORD_BITS - 1) - offset[WORD_SHIFT-1:0];
      q_op.count   = used;
      unique case (s_cmd_ff) inside
         CMD_GET: begin
            if (addr_ok) begin
               q_op.kind = OP_GET;
            end
         end
         CMD_PUT, CMD_SET, CMD_CLEAR: begin
            if (addr_ok) begin
               q_op.kind = OP_WRITE;
            end
            q_op.bit_val = (s_cmd_ff == CMD_SET) || ((s_cmd_ff == CMD_PUT) && s_bit_ff);
         end
         CMD_INVERT_ALL: begin
            q_op.kind = OP_INVERT;
         end
         CMD_CLEAR_ALL: begin
            q_op.kind = OP_WIPE;
         end
         default: begin
            q_op.kind = OP_REJECT;
         end
      endcase
   end

endmodule

// ----- src/rcbms_queue.sv -----
module rcbms_queue
   import rcbms_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   input  logic   pop,
   output logic   empty,
   output op_type head_op
);

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign head_op = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ----- src/rcbms_back.sv -----
module rcbms_back
   import rcbms_pkg::*;
#(
   parameter int MAX_WORDS = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  op_type  q_op,
   output logic    q_pop,
   output logic    clearing,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   back_state_type   state_ff, state_in;
   op_type           op_ff;
   logic [IDX_W-1:0] rd_cnt_ff;
   logic             pend_vld_ff;
   logic [AW-1:0]    pend_addr_ff;
   logic [AW-1:0]    clr_addr_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;

   logic                 out_free;
   logic                 sweep_rd;
   logic                 sweep_done;
   logic                 rsp_load;
   rsp_type              rsp_next;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic                 ram_re;
   logic [AW-1:0]        ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;

   rcbms_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAX_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sweep_rd   = (state_ff == ST_SWEEP) && (rd_cnt_ff < op_ff.count);
   assign sweep_done = (rd_cnt_ff >= op_ff.count) && !pend_vld_ff;
   assign clearing   = (state_ff == ST_CLEAR);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(MAX_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               if ((q_op.kind == OP_GET) || (q_op.kind == OP_WRITE)) begin
                  state_in = ST_MODIFY;
               end else if ((q_op.kind == OP_INVERT) || (q_op.kind == OP_WIPE)) begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_MODIFY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (sweep_done && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = clr_addr_ff;
      ram_wdata = '0;
      ram_re    = 1'b0;
      ram_raddr = q_op.word[AW-1:0];
      rsp_load  = 1'b0;
      rsp_next  = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
         end
         ST_IDLE: begin
            if (!q_empty) begin
               if ((q_op.kind == OP_GET) || (q_op.kind == OP_WRITE)) begin
                  q_pop  = 1'b1;
                  ram_re = 1'b1;
               end else if ((q_op.kind == OP_INVERT) || (q_op.kind == OP_WIPE)) begin
                  q_pop = 1'b1;
               end else if (out_free) begin
                  q_pop    = 1'b1;
                  rsp_load = 1'b1;
               end
            end
         end
         ST_MODIFY: begin
            ram_waddr = op_ff.word[AW-1:0];
            ram_wdata = ram_rdata;
            ram_wdata[op_ff.pos] = op_ff.bit_val;
            if (out_free) begin
               rsp_load         = 1'b1;
               rsp_next.ok      = 1'b1;
               rsp_next.bit_out = (op_ff.kind == OP_GET) && ram_rdata[op_ff.pos];
               ram_we           = (op_ff.kind == OP_WRITE);
            end
         end
         ST_SWEEP: begin
            ram_re    = sweep_rd;
            ram_raddr = rd_cnt_ff[AW-1:0];
            ram_we    = pend_vld_ff;
            ram_waddr = pend_addr_ff;
            ram_wdata = (op_ff.kind == OP_INVERT) ? ~ram_rdata : '0;
            if (sweep_done && out_free) begin
               rsp_load    = 1'b1;
               rsp_next.ok = 1'b1;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= sweep_rd;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= rd_cnt_ff[AW-1:0];
      if (q_pop) begin
         op_ff     <= q_op;
         rd_cnt_ff <= '0;
      end else if (sweep_rd) begin
         rd_cnt_ff <= rd_cnt_ff + IDX_W'(1);
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/row_col_bit_matrix_store_core.sv -----
// Bit matrix of row_count x col_count bits packed MSB-first into MAX_WORDS
// 32-bit words of one RAM. After reset the core sweeps every RAM word to
// zero and stalls requests meanwhile. Each request passes a registered
// front stage (index multiply, range checks) and a two-entry queue; the
// back end then does a get/put/set/clear as a RAM read, then modify and
// (for put/set/clear) write, and an invert-all or clear-all as a read and
// write sweep over the first used words, where used =
// min(ceil(rows*cols/32), MAX_WORDS). The back end takes no new single-bit
// request until the read-modify-write of the last one on the RAM is done.
module row_col_bit_matrix_store_core
   import rcbms_pkg::*;
#(
   parameter int MAX_WORDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] row_count_ff;
   logic [15:0] col_count_ff;

   logic   clearing;
   logic   q_push;
   logic   q_full;
   logic   q_pop;
   logic   q_empty;
   op_type push_op;
   op_type head_op;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_ROW_COUNT) begin
            row_count_ff <= csr_wdata;
         end
         if (csr_index == REG_COL_COUNT) begin
            col_count_ff <= csr_wdata;
         end
      end
   end

   rcbms_front #(
      .MAX_WORDS (MAX_WORDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .row_count (row_count_ff),
      .col_count (col_count_ff),
      .clearing  (clearing),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_op      (push_op)
   );

   rcbms_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (push_op),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .head_op (head_op)
   );

   rcbms_back #(
      .MAX_WORDS (MAX_WORDS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_op      (head_op),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue underflow");

   a_stall_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> req_stall)
      else $error("request taken during clearing pass");

   a_bit_needs_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> !rsp_data.bit_out)
      else $error("bit_out set on rejected request");

endmodule
